### hdl/stfg_pkg.sv
`default_nettype none

package stfg_pkg;

    localparam int PHASE_BITS         = 32;
    localparam int SINE_TABLE_ENTRIES = 1024;
    localparam int MAX_CHANNELS       = 8;

    localparam int IDX_BITS  = $clog2(SINE_TABLE_ENTRIES);
    localparam int QTR_BITS  = IDX_BITS - 2;
    localparam int CH_CAP    = (MAX_CHANNELS < 8) ? ((MAX_CHANNELS < 1) ? 1 : MAX_CHANNELS) : 8;

    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    localparam logic [30:0]        Q30_ONE        = 31'h4000_0000;
    localparam logic signed [31:0] Q30_ONE_S      = 32'sd1073741824;
    localparam logic [31:0]        HORNER_SEED_MAG = 32'd3864;

    localparam logic [2:0] STEP_SQUARE    = 3'd0;
    localparam logic [2:0] STEP_LAST_COEF = 3'd5;
    localparam logic [2:0] STEP_FINAL     = 3'd6;

    localparam logic [2:0] REG_PHASE_STEP  = 3'd0;
    localparam logic [2:0] REG_START_PHASE = 3'd1;
    localparam logic [2:0] REG_AMPLITUDE   = 3'd2;
    localparam logic [2:0] REG_DC_OFFSET   = 3'd3;
    localparam logic [2:0] REG_CHANNELS    = 3'd4;
    localparam logic [2:0] REG_FORMAT      = 3'd5;
    localparam logic [2:0] REG_MUTE        = 3'd6;

    typedef enum logic [1:0] {
        FMT_U8  = 2'd0,
        FMT_S16 = 2'd1,
        FMT_S24 = 2'd2,
        FMT_S32 = 2'd3
    } t_fmt;

    typedef enum logic [1:0] {
        SIN_IDLE,
        SIN_MUL,
        SIN_POST
    } t_sin_state;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SINE,
        BK_MIX,
        BK_SUM,
        BK_FMT,
        BK_EMIT
    } t_back_state;

    typedef struct packed {
        logic [31:0]        phase_step;
        logic signed [15:0] amplitude;
        logic signed [15:0] dc_offset;
        logic [3:0]         channels;
        t_fmt               sample_format;
        logic               mute;
    } t_cfg;

    typedef struct packed {
        logic       mute;
        logic [2:0] last_idx;
    } t_frame_req;

    typedef struct packed {
        logic                  load;
        logic [PHASE_BITS-1:0] value;
    } t_phase_load;

    function automatic logic signed [31:0] sine_coef(input logic [2:0] step);
        logic signed [31:0] coef;
        case (step)
            3'd1:    coef = 32'sd172272;
            3'd2:    coef = -32'sd5026995;
            3'd3:    coef = 32'sd85569306;
            3'd4:    coef = -32'sd693598668;
            3'd5:    coef = 32'sd1686629713;
            default: coef = 32'sd0;
        endcase
        return coef;
    endfunction

endpackage

`default_nettype wire

### hdl/sine_tone_frame_generator.sv
// Sine tone frame generator.
// Each item on the s_axis channel with tdata bit 0 set asks for one audio frame; an item
// with that bit clear is taken and produces nothing. Up to four requests wait in a queue,
// so s_axis_tready stays high while earlier frames are still being produced.
// A frame gives one item per channel on m_axis: the PCM sample in tdata, the channel
// number in tuser and tlast on the final channel. All channels carry the same sample.
// The sine value comes from a Horner polynomial on one shared 32x31 multiplier used seven
// times. After the first item of a frame, the rest follow at one item per cycle while
// m_axis_tready is high. Muted frames skip the polynomial.
// When m_axis_tready is low the output register holds its item and the generator waits;
// requests keep queueing until the queue is full.
// Registers are to be written over the APB port only while no frame is pending; the block
// does not enforce this. Writing start_phase loads the phase accumulator. Reset clears the
// queue, the output and the phase, and returns every register to its default.
`default_nettype none

module sine_tone_frame_generator import stfg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] frame_tick, [7:1] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] sample_word
    output logic        m_axis_tlast,
    output logic [2:0]  m_axis_tuser    // [2:0] channel_index
);

    logic [31:0]        r_phase_step;
    logic [31:0]        r_start_phase;
    logic signed [15:0] r_amplitude;
    logic signed [15:0] r_dc_offset;
    logic [3:0]         r_channels;
    t_fmt               r_format;
    logic               r_mute;

    logic        w_wr;
    logic [2:0]  w_reg_idx;
    t_cfg        w_cfg;
    t_phase_load w_phase_load;
    logic        w_push;
    logic        w_pop;
    logic        w_full;
    logic        w_empty;
    t_frame_req  w_req_in;
    t_frame_req  w_req_out;

    assign pready    = 1'b1;
    assign w_wr      = psel && penable && pwrite;
    assign w_reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step  <= '0;
            r_start_phase <= '0;
            r_amplitude   <= 16'sd16384;
            r_dc_offset   <= '0;
            r_channels    <= 4'd2;
            r_format      <= FMT_S16;
            r_mute        <= 1'b0;
        end else if (w_wr) begin
            case (w_reg_idx)
                REG_PHASE_STEP:  r_phase_step  <= pwdata;
                REG_START_PHASE: r_start_phase <= pwdata;
                REG_AMPLITUDE:   r_amplitude   <= $signed(pwdata[15:0]);
                REG_DC_OFFSET:   r_dc_offset   <= $signed(pwdata[15:0]);
                REG_CHANNELS:    r_channels    <= pwdata[3:0];
                REG_FORMAT:      r_format      <= t_fmt'(pwdata[1:0]);
                REG_MUTE:        r_mute        <= pwdata[0];
                default:         r_mute        <= r_mute;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_PHASE_STEP:  prdata = r_phase_step;
            REG_START_PHASE: prdata = r_start_phase;
            REG_AMPLITUDE:   prdata = {16'd0, r_amplitude};
            REG_DC_OFFSET:   prdata = {16'd0, r_dc_offset};
            REG_CHANNELS:    prdata = {28'd0, r_channels};
            REG_FORMAT:      prdata = {30'd0, r_format};
            REG_MUTE:        prdata = {31'd0, r_mute};
            default:         prdata = '0;
        endcase
    end

    assign w_cfg.phase_step    = r_phase_step;
    assign w_cfg.amplitude     = r_amplitude;
    assign w_cfg.dc_offset     = r_dc_offset;
    assign w_cfg.channels      = r_channels;
    assign w_cfg.sample_format = r_format;
    assign w_cfg.mute          = r_mute;

    assign w_phase_load.load  = w_wr && (w_reg_idx == REG_START_PHASE);
    assign w_phase_load.value = PHASE_BITS'(pwdata);

    stfg_front u_front (
        .i_tvalid (s_axis_tvalid),
        .i_tick   (s_axis_tdata[0]),
        .i_full   (w_full),
        .i_cfg    (w_cfg),
        .o_tready (s_axis_tready),
        .o_push   (w_push),
        .o_req    (w_req_in)
    );

    stfg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_req_in),
        .i_pop   (w_pop),
        .o_data  (w_req_out),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    stfg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_phase_load (w_phase_load),
        .i_empty      (w_empty),
        .i_req        (w_req_out),
        .o_pop        (w_pop),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_tdata      (m_axis_tdata),
        .o_tuser      (m_axis_tuser),
        .o_tlast      (m_axis_tlast)
    );

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("frame request queue written while full");

    a_frame_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast
        |=> !m_axis_tvalid || (m_axis_tuser == 3'd0))
        else $error("frame does not start at channel zero");

    a_channel_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast
        |=> m_axis_tvalid && (m_axis_tuser == 3'($past(m_axis_tuser) + 3'd1)))
        else $error("channel items not consecutive within a frame");

endmodule

`default_nettype wire

### hdl/stfg_front.sv
`default_nettype none

module stfg_front import stfg_pkg::*; (
    input  logic       i_tvalid,
    input  logic       i_tick,
    input  logic       i_full,
    input  t_cfg       i_cfg,
    output logic       o_tready,
    output logic       o_push,
    output t_frame_req o_req
);

    logic [3:0] w_count;

    always_comb begin
        if (i_cfg.channels == 4'd0) begin
            w_count = 4'd1;
        end else if (i_cfg.channels > 4'(CH_CAP)) begin
            w_count = 4'(CH_CAP);
        end else begin
            w_count = i_cfg.channels;
        end
    end

    // A tick of zero is taken but asks for nothing.
    assign o_tready       = !i_full;
    assign o_push         = i_tvalid && !i_full && i_tick;
    assign o_req.mute     = i_cfg.mute;
    assign o_req.last_idx = 3'(w_count - 4'd1);

endmodule

`default_nettype wire

### hdl/stfg_fifo.sv
`default_nettype none

module stfg_fifo import stfg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_frame_req i_data,
    input  logic       i_pop,
    output t_frame_req o_data,
    output logic       o_empty,
    output logic       o_full
);

    t_frame_req                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0]  r_wr_ptr;
    logic [FIFO_PTR_BITS-1:0]  r_rd_ptr;
    logic [FIFO_CNT_BITS-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FIFO_CNT_BITS'(FIFO_DEPTH));

endmodule

`default_nettype wire

### hdl/stfg_sine.sv
`default_nettype none

module stfg_sine import stfg_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [PHASE_BITS-1:0] i_phase,
    output logic                  o_done,
    output logic signed [15:0]    o_sine
);

    t_sin_state         r_state, n_state;
    logic [2:0]         r_step, n_step;
    logic [1:0]         r_quad, n_quad;
    logic [30:0]        r_u, n_u;
    logic [30:0]        r_u2, n_u2;
    logic [31:0]        r_opa, n_opa;
    logic               r_neg, n_neg;
    logic [30:0]        r_opb, n_opb;
    logic [62:0]        r_prod, n_prod;
    logic               r_pneg, n_pneg;
    logic               r_done, n_done;
    logic signed [15:0] r_sine, n_sine;

    logic [IDX_BITS-1:0] w_idx;
    logic [30:0]         w_u0;
    logic [30:0]         w_u;
    logic [31:0]         w_q;
    logic signed [31:0]  w_sq;
    logic signed [31:0]  w_r;
    logic [31:0]         w_rmag;
    logic [30:0]         w_sc;
    logic [16:0]         w_rnd;
    logic [14:0]         w_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SIN_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_quad <= n_quad;
        r_u    <= n_u;
        r_u2   <= n_u2;
        r_opa  <= n_opa;
        r_neg  <= n_neg;
        r_opb  <= n_opb;
        r_prod <= n_prod;
        r_pneg <= n_pneg;
        r_sine <= n_sine;
    end

    always_comb begin
        w_idx  = i_phase[PHASE_BITS-1 -: IDX_BITS];
        w_u0   = 31'(w_idx[QTR_BITS-1:0]) << (30 - QTR_BITS);
        w_u    = w_idx[QTR_BITS] ? (Q30_ONE - w_u0) : w_u0;

        // Product of the previous step, truncated toward zero in Q30.
        w_q    = r_prod[61:30];
        w_sq   = r_pneg ? -$signed(w_q) : $signed(w_q);
        w_r    = sine_coef(r_step) + w_sq;
        w_rmag = w_r[31] ? 32'(-w_r) : 32'(w_r);

        if (w_sq < 32'sd0) begin
            w_sc = '0;
        end else if (w_sq > Q30_ONE_S) begin
            w_sc = Q30_ONE;
        end else begin
            w_sc = w_sq[30:0];
        end
        w_rnd = 17'((32'(w_sc) + 32'd16384) >> 15);
        w_mag = (w_rnd > 17'd32767) ? 15'h7fff : w_rnd[14:0];
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_quad  = r_quad;
        n_u     = r_u;
        n_u2    = r_u2;
        n_opa   = r_opa;
        n_neg   = r_neg;
        n_opb   = r_opb;
        n_prod  = r_prod;
        n_pneg  = r_pneg;
        n_done  = 1'b0;
        n_sine  = r_sine;
        case (r_state)
            SIN_IDLE: begin
                if (i_start) begin
                    n_quad  = w_idx[IDX_BITS-1 -: 2];
                    n_u     = w_u;
                    n_opa   = 32'(w_u);
                    n_neg   = 1'b0;
                    n_opb   = w_u;
                    n_step  = STEP_SQUARE;
                    n_state = SIN_MUL;
                end
            end
            SIN_MUL: begin
                n_prod  = 63'(r_opa) * 63'(r_opb);
                n_pneg  = r_neg;
                n_state = SIN_POST;
            end
            SIN_POST: begin
                case (r_step)
                    STEP_SQUARE: begin
                        n_u2    = w_q[30:0];
                        n_opa   = HORNER_SEED_MAG;
                        n_neg   = 1'b1;
                        n_opb   = w_q[30:0];
                        n_step  = r_step + 3'd1;
                        n_state = SIN_MUL;
                    end
                    STEP_FINAL: begin
                        n_sine  = r_quad[1] ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
                        n_done  = 1'b1;
                        n_state = SIN_IDLE;
                    end
                    default: begin
                        n_opa   = w_rmag;
                        n_neg   = w_r[31];
                        n_opb   = (r_step == STEP_LAST_COEF) ? r_u : r_u2;
                        n_step  = r_step + 3'd1;
                        n_state = SIN_MUL;
                    end
                endcase
            end
            default: begin
                n_state = SIN_IDLE;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_sine = r_sine;

endmodule

`default_nettype wire

### hdl/stfg_back.sv
`default_nettype none

module stfg_back import stfg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_phase_load i_phase_load,
    input  logic        i_empty,
    input  t_frame_req  i_req,
    output logic        o_pop,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [31:0] o_tdata,
    output logic [2:0]  o_tuser,
    output logic        o_tlast
);

    t_back_state           r_state, n_state;
    logic [PHASE_BITS-1:0] r_phase, n_phase;
    logic [2:0]            r_last_idx, n_last_idx;
    logic [2:0]            r_ch, n_ch;
    logic signed [31:0]    r_mix, n_mix;
    logic signed [16:0]    r_v, n_v;
    logic [31:0]           r_word, n_word;
    logic                  r_out_valid, n_out_valid;
    logic [31:0]           r_out_data, n_out_data;
    logic [2:0]            r_out_ch, n_out_ch;
    logic                  r_out_last, n_out_last;

    logic                  w_sine_start;
    logic                  w_sine_done;
    logic signed [15:0]    w_sine;

    logic signed [32:0]    w_mixr;
    logic signed [32:0]    w_p;
    logic signed [18:0]    w_vsum;
    logic signed [25:0]    w_t8;
    logic signed [32:0]    w_t16;
    logic signed [32:0]    w_t16a;
    logic signed [48:0]    w_t32;
    logic signed [48:0]    w_t32a;
    logic [31:0]           w_fmt_word;

    stfg_sine u_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sine_start),
        .i_phase (r_phase),
        .o_done  (w_sine_done),
        .o_sine  (w_sine)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_idx <= n_last_idx;
        r_ch       <= n_ch;
        r_mix      <= n_mix;
        r_v        <= n_v;
        r_word     <= n_word;
        r_out_data <= n_out_data;
        r_out_ch   <= n_out_ch;
        r_out_last <= n_out_last;
    end

    always_comb begin
        w_mixr = 33'(r_mix) + 33'sd16384;
        w_p    = w_mixr >>> 15;
        w_vsum = 19'($signed(i_cfg.dc_offset)) + $signed(w_p[18:0]);

        // Scalings by 255, 32767 and 2^31-1 are shift and subtract.
        w_t8   = (26'(r_v) <<< 8) - 26'(r_v) + 26'sd8355840;
        w_t16  = (33'(r_v) <<< 15) - 33'(r_v);
        w_t16a = w_t16 + (w_t16[32] ? 33'sd32767 : 33'sd0);
        w_t32  = (49'(r_v) <<< 31) - 49'(r_v);
        w_t32a = w_t32 + (w_t32[48] ? 49'sd32767 : 49'sd0);

        case (i_cfg.sample_format)
            FMT_U8:  w_fmt_word = {24'd0, w_t8[23:16]};
            FMT_S16: w_fmt_word = {16'd0, w_t16a[30:15]};
            FMT_S24: w_fmt_word = {8'd0, w_t32a[46:23]};
            FMT_S32: w_fmt_word = w_t32a[46:15];
            default: w_fmt_word = '0;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_last_idx   = r_last_idx;
        n_ch         = r_ch;
        n_mix        = r_mix;
        n_v          = r_v;
        n_word       = r_word;
        n_out_valid  = r_out_valid && !i_tready;
        n_out_data   = r_out_data;
        n_out_ch     = r_out_ch;
        n_out_last   = r_out_last;
        o_pop        = 1'b0;
        w_sine_start = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop      = 1'b1;
                    n_last_idx = i_req.last_idx;
                    n_ch       = '0;
                    if (i_req.mute) begin
                        n_word  = '0;
                        n_state = BK_EMIT;
                    end else begin
                        w_sine_start = 1'b1;
                        n_phase      = r_phase + PHASE_BITS'(i_cfg.phase_step);
                        n_state      = BK_SINE;
                    end
                end
            end
            BK_SINE: begin
                if (w_sine_done) begin
                    n_state = BK_MIX;
                end
            end
            BK_MIX: begin
                n_mix   = i_cfg.amplitude * w_sine;
                n_state = BK_SUM;
            end
            BK_SUM: begin
                if (w_vsum < -19'sd32768) begin
                    n_v = -17'sd32768;
                end else if (w_vsum > 19'sd32768) begin
                    n_v = 17'sd32768;
                end else begin
                    n_v = 17'(w_vsum);
                end
                n_state = BK_FMT;
            end
            BK_FMT: begin
                n_word  = w_fmt_word;
                n_state = BK_EMIT;
            end
            BK_EMIT: begin
                if (!r_out_valid || i_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_word;
                    n_out_ch    = r_ch;
                    n_out_last  = (r_ch == r_last_idx);
                    if (r_ch == r_last_idx) begin
                        n_state = BK_IDLE;
                    end else begin
                        n_ch = r_ch + 3'd1;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
        if (i_phase_load.load) begin
            n_phase = i_phase_load.value;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;
    assign o_tuser  = r_out_ch;
    assign o_tlast  = r_out_last;

endmodule

`default_nettype wire

### bench/sine_tone_frame_generator_test.sv
`default_nettype none

module sine_tone_frame_generator_test;
    import stfg_pkg::*;

    localparam logic [2:0] REG_SPARE = 3'd7;
    localparam int DRAIN_CYCLES = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_TICKS = 205;
    localparam longint Q30 = 64'sd1073741824;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  chan;
        logic        last;
    } t_pcm_item;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PERIODIC,
        RX_LONG
    } t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [0] frame_tick, [7:1] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [31:0] sample_word
    logic        m_axis_tlast;
    logic [2:0]  m_axis_tuser;        // [2:0] channel_index

    sine_tone_frame_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Mirror of the generator's registers and phase.
    logic [31:0]        tone_step = '0;
    logic [31:0]        tone_phase = '0;
    logic signed [15:0] tone_amp = 16'sd16384;
    logic signed [15:0] tone_dc = '0;
    logic [3:0]         tone_chans = 4'd2;
    t_fmt               tone_fmt = FMT_S16;
    logic               tone_mute = 1'b0;

    t_pcm_item expected_samples[$];
    int errors = 0;
    int items_sent = 0;
    int ticks_sent = 0;
    int samples_checked = 0;
    int reg_writes = 0;
    int burst_left = 0;
    int idle_cycles = 0;

    t_rx_mode rx_mode = RX_OPEN;
    int       rx_span = 0;
    int       rx_hold = 0;

    function automatic longint q30_mul(input longint a, input longint b);
        if (a < 0)
            return -(((-a) * b) >>> 30);
        return (a * b) >>> 30;
    endfunction

    function automatic longint tone_sine(input logic [31:0] ph);
        longint unsigned idx, v4, quad, rem;
        longint u, u2, r, s;
        idx = (64'(ph) * 64'(SINE_TABLE_ENTRIES)) >> PHASE_BITS;
        v4 = idx * 4;
        quad = (v4 / 64'(SINE_TABLE_ENTRIES)) & 64'd3;
        rem = v4 % 64'(SINE_TABLE_ENTRIES);
        u = longint'((rem << 30) / 64'(SINE_TABLE_ENTRIES));
        if ((quad & 64'd1) != 0)
            u = Q30 - u;
        u2 = q30_mul(u, u);
        r = -64'sd3864;
        r = 64'sd172272 + q30_mul(r, u2);
        r = -64'sd5026995 + q30_mul(r, u2);
        r = 64'sd85569306 + q30_mul(r, u2);
        r = -64'sd693598668 + q30_mul(r, u2);
        r = 64'sd1686629713 + q30_mul(r, u2);
        s = q30_mul(r, u);
        if (s < 0)
            s = 0;
        if (s > Q30)
            s = Q30;
        s = (s + 16384) >>> 15;
        if (s > 32767)
            s = 32767;
        return (quad >= 2) ? -s : s;
    endfunction

    function automatic logic [31:0] tone_word();
        longint prod, v, w;
        prod = longint'(tone_amp) * tone_sine(tone_phase);
        v = longint'(tone_dc) + ((prod + 16384) >>> 15);
        if (v < -32768)
            v = -32768;
        if (v > 32768)
            v = 32768;
        case (tone_fmt)
            FMT_U8: begin
                w = (v * 255 + 64'sd8355840) / 65536;
                return {24'b0, w[7:0]};
            end
            FMT_S16: begin
                w = v * 32767 / 32768;
                return {16'b0, w[15:0]};
            end
            FMT_S24: begin
                w = v * 64'sd2147483647 / 32768;
                return {8'b0, w[31:8]};
            end
            default: begin
                w = v * 64'sd2147483647 / 32768;
                return w[31:0];
            end
        endcase
    endfunction

    task automatic predict_frame(input logic tick);
        int n;
        logic [31:0] word;
        t_pcm_item item;
        if (tick) begin
            n = (tone_chans == 0) ? 1 : int'(tone_chans);
            if (n > CH_CAP)
                n = CH_CAP;
            word = tone_mute ? 32'd0 : tone_word();
            for (int k = 0; k < n; k++) begin
                item.word = word;
                item.chan = k[2:0];
                item.last = (k == n - 1);
                expected_samples.push_back(item);
            end
            if (!tone_mute)
                tone_phase = tone_phase + tone_step;
        end
    endtask

    task automatic send_item(input logic tick);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'b0, tick};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predict_frame(tick);
        burst_left--;
        items_sent++;
        if (tick)
            ticks_sent++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        case (idx)
            REG_PHASE_STEP:  tone_step = data;
            REG_START_PHASE: tone_phase = data;
            REG_AMPLITUDE:   tone_amp = data[15:0];
            REG_DC_OFFSET:   tone_dc = data[15:0];
            REG_CHANNELS:    tone_chans = data[3:0];
            REG_FORMAT:      tone_fmt = t_fmt'(data[1:0]);
            REG_MUTE:        tone_mute = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        reg_writes++;
    endtask

    function automatic logic [31:0] pick_q15();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_8000;
            1: return 32'h0000_7FFF;
            2: return 32'h0;
            default: return {{16{1'b0}}, 16'($urandom)};
        endcase
    endfunction

    task automatic test_defaults();
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b1);
    endtask

    task automatic test_quadrants();
        settle();
        write_reg(REG_PHASE_STEP, 32'h4000_0000);
        write_reg(REG_START_PHASE, 32'h0);
        write_reg(REG_AMPLITUDE, 32'h7FFF);
        write_reg(REG_CHANNELS, 32'd8);
        write_reg(REG_FORMAT, 32'(FMT_S32));
        repeat (4) send_item(1'b1);
    endtask

    task automatic test_saturation();
        settle();
        write_reg(REG_PHASE_STEP, 32'h0);
        write_reg(REG_START_PHASE, 32'h4000_0000);
        write_reg(REG_DC_OFFSET, 32'h7FFF);
        write_reg(REG_CHANNELS, 32'd3);
        for (int f = 0; f < 4; f++) begin
            settle();
            write_reg(REG_FORMAT, 32'(f));
            send_item(1'b1);
        end
        settle();
        write_reg(REG_AMPLITUDE, 32'hFFFF_8000);
        write_reg(REG_DC_OFFSET, 32'hFFFF_8000);
        for (int f = 0; f < 4; f++) begin
            settle();
            write_reg(REG_FORMAT, 32'(f));
            send_item(1'b1);
        end
    endtask

    task automatic test_channel_limits();
        settle();
        write_reg(REG_FORMAT, 32'(FMT_U8));
        write_reg(REG_AMPLITUDE, 32'd16384);
        write_reg(REG_DC_OFFSET, 32'd0);
        write_reg(REG_PHASE_STEP, 32'h0123_4567);
        write_reg(REG_CHANNELS, 32'd0);
        send_item(1'b1);
        settle();
        write_reg(REG_CHANNELS, 32'd9);
        send_item(1'b1);
        settle();
        write_reg(REG_CHANNELS, 32'd15);
        send_item(1'b1);
    endtask

    task automatic test_mute_hold();
        settle();
        write_reg(REG_FORMAT, 32'(FMT_S24));
        write_reg(REG_CHANNELS, 32'd2);
        write_reg(REG_MUTE, 32'd1);
        send_item(1'b1);
        send_item(1'b1);
        settle();
        write_reg(REG_MUTE, 32'd0);
        send_item(1'b1);
    endtask

    task automatic test_phase_wrap();
        settle();
        write_reg(REG_START_PHASE, 32'hFFFF_FF00);
        write_reg(REG_PHASE_STEP, 32'h8000_0100);
        write_reg(REG_FORMAT, 32'(FMT_S16));
        send_item(1'b1);
        send_item(1'b1);
    endtask

    task automatic test_unknown_register();
        settle();
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        send_item(1'b1);
    endtask

    task automatic test_random_tones();
        int ticks;
        int span;
        logic tick;
        ticks = 0;
        while (ticks < RANDOM_TICKS) begin
            settle();
            case ($urandom_range(0, 3))
                0: write_reg(REG_PHASE_STEP, $urandom);
                1: write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
                2: write_reg(REG_PHASE_STEP, $urandom_range(0, 32'h00FF_FFFF));
                default: ;
            endcase
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_START_PHASE, $urandom);
            if ($urandom_range(0, 1) == 0)
                write_reg(REG_AMPLITUDE, pick_q15());
            if ($urandom_range(0, 1) == 0)
                write_reg(REG_DC_OFFSET, ($urandom_range(0, 2) == 0) ? pick_q15()
                                         : 32'($signed($urandom_range(0, 8191)) - 4096));
            if ($urandom_range(0, 1) == 0)
                write_reg(REG_CHANNELS, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                                   : $urandom_range(1, 8));
            if ($urandom_range(0, 1) == 0)
                write_reg(REG_FORMAT, $urandom_range(0, 3));
            write_reg(REG_MUTE, ($urandom_range(0, 7) == 0) ? 32'd1 : 32'd0);
            span = $urandom_range(8, 30);
            for (int k = 0; k < span && ticks < RANDOM_TICKS; k++) begin
                tick = ($urandom_range(0, 7) != 0);
                send_item(tick);
                if (tick)
                    ticks++;
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (rx_span == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_span <= $urandom_range(20, 120);
        end else begin
            rx_span <= rx_span - 1;
        end
        case (rx_mode)
            RX_OPEN:     m_axis_tready <= 1'b1;
            RX_RANDOM:   m_axis_tready <= $urandom_range(0, 1);
            RX_PERIODIC: m_axis_tready <= (rx_span % 4) != 0;
            default: begin
                if (rx_hold == 0) begin
                    rx_hold <= $urandom_range(1, 20);
                    m_axis_tready <= !m_axis_tready;
                end else begin
                    rx_hold <= rx_hold - 1;
                end
            end
        endcase
    end

    always @(posedge i_clk) begin
        t_pcm_item want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_samples.size() == 0) begin
                $error("unexpected item: sample_word %h channel_index %0d last_channel %0b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                errors++;
            end else begin
                want = expected_samples.pop_front();
                samples_checked++;
                if (m_axis_tdata !== want.word) begin
                    $error("sample_word: expected %h, got %h", want.word, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser !== want.chan) begin
                    $error("channel_index: expected %0d, got %0d", want.chan, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_channel: expected %0b, got %0b", want.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_defaults();
        test_quadrants();
        test_saturation();
        test_channel_limits();
        test_mute_hold();
        test_phase_wrap();
        test_unknown_register();
        test_random_tones();
        settle();
        if (expected_samples.size() != 0) begin
            $error("%0d expected items never arrived", expected_samples.size());
            errors += expected_samples.size();
        end
        $display("Sent %0d items (%0d frame requests) over %0d register writes,",
                 items_sent, ticks_sent, reg_writes);
        $display("checked %0d channel samples across all formats, mute and channel limits.",
                 samples_checked);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
